// ===== src/cta_pkg.sv =====
// ----------------------------------------------------------------------------
// cta_pkg: shared types and constants of the convolution tap accumulator
// Widths of the channel sums, the divider and the control struct that the
// sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package cta_pkg;

  localparam int unsigned AccW    = 26;  // channel sum width
  localparam int unsigned QuoW    = AccW + 1;  // quotient of -2^25 / -1 needs one more bit
  localparam int unsigned ChanW   = 8;
  localparam int unsigned WeightW = 11;
  localparam int unsigned DivW    = 16;
  localparam int unsigned BiasW   = 10;
  localparam int unsigned NumChan = 4;
  localparam int unsigned ChanSelW = $clog2(NumChan);
  localparam int unsigned ProdW   = ChanW + 1 + WeightW;
  localparam int unsigned DivCntW = $clog2(AccW);

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  // Register indexes of the configuration port.
  localparam logic CfgDivisor = 1'b0;
  localparam logic CfgBias    = 1'b1;

  typedef struct packed {
    logic                en;   // add weight times channel into the selected sum
    logic                clr;  // clear the selected sum
    logic [ChanSelW-1:0] sel;  // channel: 0 blue, 1 green, 2 red, 3 alpha
  } mac_ctrl_t;

endpackage

// ===== src/image_convolution_tap_accumulator.sv =====
// ----------------------------------------------------------------------------
// image_convolution_tap_accumulator: one output pixel of a 2D convolution
// Accumulates weight times channel over a stream of kernel taps, then
// divides, biases, clamps and packs the ARGB8888 result.
// ----------------------------------------------------------------------------
// Input channel: one beat per kernel tap (pixel_argb_i, tap_weight_i,
// last_tap_i) under in_valid_i / in_ready_o. Output channel: one beat per
// output pixel (result_argb_o) under out_valid_o / out_ready_i.
// A tap is taken through one shared multiplier, one color channel a cycle,
// so in_ready_o is high again once all four channels have been summed.
// On a last tap each of the four sums then goes through one shared serial
// divider, one quotient bit a cycle, and the result is then moved into
// the output register once that register is free; division is skipped
// when the divisor register is zero.
// Configuration writes (index 0 divisor, index 1 bias) take effect at once;
// the user makes them only while the block is idle; it is not enforced.
// Reset clears the sums, sets divisor to 1 and bias to 0, and empties the
// output register. A result waiting for out_ready_i does not block further
// taps; only a following last tap waits until that result has been taken.
// ----------------------------------------------------------------------------
module image_convolution_tap_accumulator import cta_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [31:0]               pixel_argb_i,
  input  logic signed [WeightW-1:0] tap_weight_i,
  input  logic                      last_tap_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [31:0]               result_argb_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [DivW-1:0]           cfg_wdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [ChanSelW-1:0]      ch_q, ch_d;
  logic                     out_valid_q, out_valid_d;
  logic [31:0]              out_data_q;
  logic [31:0]              pixel_q;
  logic signed [WeightW-1:0] weight_q;
  logic                     last_q;
  logic signed [QuoW-1:0]   val_q;
  logic [31:0]              res_q;
  logic signed [DivW-1:0]   divisor_q;
  logic signed [BiasW-1:0]  bias_q;

  mac_ctrl_t                mac_ctrl;
  logic signed [AccW-1:0]   sum;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic signed [QuoW-1:0]   quotient;
  logic                     in_acc;
  logic                     out_load;
  logic signed [QuoW:0]     biased;
  logic [ChanW-1:0]         chan_byte;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_PUSH) && (!out_valid_q || out_ready_i);

  assign mac_ctrl.en  = (state_q == S_MAC);
  assign mac_ctrl.clr = (state_q == S_FIN);
  assign mac_ctrl.sel = ch_q;

  assign div_start = (state_q == S_DIV) && (divisor_q != '0);

  cta_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .chan_i   (pixel_q[{ch_q, 3'b000} +: ChanW]),
    .weight_i (weight_q),
    .sum_o    (sum)
  );

  cta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (divisor_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Bias and clamp to the 0..255 range of one color channel.
  assign biased = {val_q[QuoW-1], val_q} + {{(QuoW+1-BiasW){bias_q[BiasW-1]}}, bias_q};

  always_comb begin
    if (biased[QuoW]) begin
      chan_byte = '0;
    end else if (biased > $signed({{(QuoW+1-ChanW){1'b0}}, ChanMax})) begin
      chan_byte = ChanMax;
    end else begin
      chan_byte = biased[ChanW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_MAC;
          ch_d    = '0;
        end
      end
      S_MAC: begin
        ch_d = ch_q + 1'b1;
        if (ch_q == ChanSelW'(NumChan - 1)) begin
          state_d = last_q ? S_DIV : S_IDLE;
        end
      end
      S_DIV: begin
        state_d = (divisor_q == '0) ? S_FIN : S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ch_d = ch_q + 1'b1;
        if (ch_q == ChanSelW'(NumChan - 1)) begin
          state_d = S_PUSH;
        end else begin
          state_d = S_DIV;
        end
      end
      S_PUSH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      divisor_q   <= DivW'(1);
      bias_q      <= '0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDivisor: divisor_q <= $signed(cfg_wdata_i);
          CfgBias:    bias_q    <= $signed(cfg_wdata_i[BiasW-1:0]);
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pixel_q  <= pixel_argb_i;
      weight_q <= tap_weight_i;
      last_q   <= last_tap_i;
    end
    if (state_q == S_DIV && divisor_q == '0) begin
      val_q <= {sum[AccW-1], sum};
    end else if (state_q == S_WAIT && div_done) begin
      val_q <= quotient;
    end
    if (state_q == S_FIN) begin
      res_q[{ch_q, 3'b000} +: ChanW] <= chan_byte;
    end
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_argb_o = out_data_q;

  a_tap_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##4 (state_q == S_MAC && ch_q == 2'd3))
    else $error("tap did not take four multiply cycles");

  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("finished pixel not presented");

  a_div_only_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == S_WAIT)
    else $error("divider running outside the wait state");

  a_wait_needs_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

endmodule

// ===== src/cta_mac.sv =====
// ----------------------------------------------------------------------------
// cta_mac: shared multiply-accumulate unit
// Holds the four channel sums and one 8 x 11 multiplier that serves each
// channel in turn under control of the sequencer.
// ----------------------------------------------------------------------------
module cta_mac import cta_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mac_ctrl_t                 ctrl_i,
  input  logic [ChanW-1:0]          chan_i,
  input  logic signed [WeightW-1:0] weight_i,
  output logic signed [AccW-1:0]    sum_o
);

  logic [AccW-1:0]         sum_q [NumChan];
  logic signed [ProdW-1:0] prod;
  logic [AccW-1:0]         sum_d;

  assign prod  = $signed({1'b0, chan_i}) * weight_i;
  assign sum_d = sum_q[ctrl_i.sel] + {{(AccW-ProdW){prod[ProdW-1]}}, prod};
  assign sum_o = $signed(sum_q[ctrl_i.sel]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChan; i++) begin
        sum_q[i] <= '0;
      end
    end else if (ctrl_i.clr) begin
      sum_q[ctrl_i.sel] <= '0;
    end else if (ctrl_i.en) begin
      sum_q[ctrl_i.sel] <= sum_d;
    end
  end

  a_clr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clr |=> sum_q[$past(ctrl_i.sel)] == '0)
    else $error("channel sum not cleared");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.clr && ctrl_i.en))
    else $error("clear and accumulate requested together");

  a_other_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.en && ctrl_i.sel != 2'd0) |=> $stable(sum_q[0]))
    else $error("unselected channel sum changed");

endmodule

// ===== src/cta_div.sv =====
// ----------------------------------------------------------------------------
// cta_div: iterative signed divider
// Restoring division of magnitudes, one quotient bit per cycle, with the
// sign applied at the end so that the quotient truncates toward zero.
// ----------------------------------------------------------------------------
module cta_div import cta_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [AccW-1:0]  dividend_i,
  input  logic signed [DivW-1:0]  divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [QuoW-1:0]  quotient_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [AccW-1:0]    quo_q;
  logic [DivW-1:0]    rem_q;
  logic [DivW-1:0]    dmag_q;
  logic               neg_q;

  logic [AccW-1:0]    dend_mag;
  logic [DivW-1:0]    dsor_mag;
  logic [DivW:0]      rem_sh;
  logic               ge;
  logic [DivW-1:0]    rem_sub;

  assign dend_mag = dividend_i[AccW-1] ? (AccW'(0) - AccW'(dividend_i)) : AccW'(dividend_i);
  assign dsor_mag = divisor_i[DivW-1] ? (DivW'(0) - DivW'(divisor_i)) : DivW'(divisor_i);

  // The remainder stays below the divisor, so the difference fits in DivW bits.
  assign rem_sh  = {rem_q, quo_q[AccW-1]};
  assign ge      = rem_sh >= {1'b0, dmag_q};
  assign rem_sub = rem_sh[DivW-1:0] - dmag_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(AccW - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dend_mag;
      rem_q  <= '0;
      dmag_q <= dsor_mag;
      neg_q  <= dividend_i[AccW-1] ^ divisor_i[DivW-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[AccW-2:0], ge};
      rem_q <= ge ? rem_sub : rem_sh[DivW-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? $signed(QuoW'(0) - {1'b0, quo_q}) : $signed({1'b0, quo_q});

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finished run");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##27 done_q)
    else $error("divider run has the wrong length");

endmodule
